// ===== sv/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared sizes, register indexes, reset values and word types of the sensor
// presence qualifier.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int WINDOW  = 16;
  localparam int SMP_W   = 10;
  localparam int SUM_W   = $clog2(WINDOW * ((1 << SMP_W) - 1) + 1);
  localparam int CNT_W   = $clog2(WINDOW + 1);
  localparam int STEP_W  = $clog2(SUM_W + 1);
  localparam int LIMIT_W = 16;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 3;

  localparam logic [SMP_W-1:0]   VALID_MIN_RST = SMP_W'(200);
  localparam logic [SMP_W-1:0]   VALID_MAX_RST = SMP_W'(950);
  localparam logic [SMP_W-1:0]   RISE_RST      = SMP_W'(650);
  localparam logic [SMP_W-1:0]   FALL_RST      = SMP_W'(580);
  localparam logic [LIMIT_W-1:0] LIMIT_RST     = LIMIT_W'(1200);
  localparam logic [LIMIT_W-1:0] TICK_SAT      = '1;

  typedef enum logic [IDX_W-1:0] {
    REG_VALID_MIN = 3'd0,
    REG_VALID_MAX = 3'd1,
    REG_RISE      = 3'd2,
    REG_FALL      = 3'd3,
    REG_LOSS      = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic             cmd;
    logic [SMP_W-1:0] sample;
  } in_word_t;

  typedef struct packed {
    logic [SMP_W-1:0] mean_value;
    logic             none_valid;
    logic             present;
    logic             lost;
  } out_word_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
    logic             wrap;
  } acc_t;

endpackage

// ===== sv/sensor_presence_qualifier.sv =====
// ----------------------------------------------------------------------------
// sensor_presence_qualifier
// Window average of qualified sensor samples with a hysteresis presence flag
// and a saturating absence timer driven by millisecond ticks.
//
//   channel   signals                              word
//   input     in_valid_i / in_ready_o / in_word_i  cmd, sample
//   output    out_valid_o / out_ready_i / out_word_o
//                                                  mean, none, present, lost
//   config    cfg_we_i / cfg_idx_i / cfg_data_i    register write, no wait
//
// A tick or a sample that does not close the window leaves the block idle,
// ready for another input. The sample that closes the window starts the
// bit-serial divider, producing one quotient bit per cycle, and the block
// steps through S_START, S_DIV and S_FIN. Input is stalled until the result
// is loaded into the output register, which waits only if the previous
// result has not been taken. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module sensor_presence_qualifier (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  spq_pkg::in_word_t         in_word_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output spq_pkg::out_word_t        out_word_o,
  input  logic                      cfg_we_i,
  input  logic [spq_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [spq_pkg::CFG_W-1:0] cfg_data_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_DIV,
    S_FIN
  } state_e;

  state_e                      state_q, state_d;
  logic [spq_pkg::SMP_W-1:0]   vmin_q, vmax_q, rise_q, fall_q;
  logic [spq_pkg::LIMIT_W-1:0] limit_q;
  logic                        pres_q, pres_d;
  logic [spq_pkg::LIMIT_W-1:0] abs_q, abs_d;
  logic                        none_q, none_d;
  logic                        ov_q, ov_d;
  spq_pkg::out_word_t          ow_q, ow_d;

  logic                        in_acc;
  logic                        smp_en;
  logic                        tick_en;
  logic                        div_start;
  logic                        div_busy;
  logic [spq_pkg::SMP_W-1:0]   quot;
  spq_pkg::acc_t               acc;
  logic                        slot_free;
  logic                        p_rise;
  logic                        p_new;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign smp_en     = in_acc && !in_word_i.cmd;
  assign tick_en    = in_acc && in_word_i.cmd;
  assign div_start  = (state_q == S_START);
  assign slot_free  = !ov_q || out_ready_i;

  spq_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .smp_en_i    (smp_en),
    .sample_i    (in_word_i.sample),
    .valid_min_i (vmin_q),
    .valid_max_i (vmax_q),
    .clr_i       (div_start),
    .acc_o       (acc)
  );

  spq_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc.sum),
    .divisor_i  (acc.count),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vmin_q  <= spq_pkg::VALID_MIN_RST;
      vmax_q  <= spq_pkg::VALID_MAX_RST;
      rise_q  <= spq_pkg::RISE_RST;
      fall_q  <= spq_pkg::FALL_RST;
      limit_q <= spq_pkg::LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        spq_pkg::REG_VALID_MIN: vmin_q  <= cfg_data_i[spq_pkg::SMP_W-1:0];
        spq_pkg::REG_VALID_MAX: vmax_q  <= cfg_data_i[spq_pkg::SMP_W-1:0];
        spq_pkg::REG_RISE:      rise_q  <= cfg_data_i[spq_pkg::SMP_W-1:0];
        spq_pkg::REG_FALL:      fall_q  <= cfg_data_i[spq_pkg::SMP_W-1:0];
        spq_pkg::REG_LOSS:      limit_q <= cfg_data_i[spq_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign p_rise = pres_q || (quot >= rise_q);
  assign p_new  = none_q ? pres_q : (p_rise && !(quot < fall_q));

  always_comb begin
    state_d = state_q;
    pres_d  = pres_q;
    abs_d   = abs_q;
    none_d  = none_q;
    ov_d    = ov_q && !out_ready_i;
    ow_d    = ow_q;
    case (state_q)
      S_IDLE: begin
        if (tick_en && !pres_q && (abs_q != spq_pkg::TICK_SAT)) begin
          abs_d = abs_q + 1'b1;
        end
        if (smp_en && acc.wrap) begin
          state_d = S_START;
        end
      end
      S_START: begin
        none_d  = (acc.count == '0);
        state_d = S_DIV;
      end
      S_DIV: begin
        if (!div_busy) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          pres_d = p_new;
          if (p_new) begin
            abs_d = '0;
          end
          ov_d = 1'b1;
          ow_d = '{mean_value: none_q ? '0 : quot,
                   none_valid: none_q,
                   present:    p_new,
                   lost:       !p_new && (abs_q >= limit_q)};
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pres_q  <= 1'b0;
      abs_q   <= '0;
      none_q  <= 1'b0;
      ov_q    <= 1'b0;
      ow_q    <= '0;
    end else begin
      state_q <= state_d;
      pres_q  <= pres_d;
      abs_q   <= abs_d;
      none_q  <= none_d;
      ov_q    <= ov_d;
      ow_q    <= ow_d;
    end
  end

  assign out_valid_o = ov_q;
  assign out_word_o  = ow_q;

  a_present_not_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_word_o.present && out_word_o.lost))
    else $error("present and lost raised together");

  a_none_zero_mean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.none_valid) |-> (out_word_o.mean_value == '0))
    else $error("empty window reported a non-zero mean");

  a_present_no_absence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pres_q |-> (abs_q == '0))
    else $error("absence timer running while present");

  a_div_launch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_START) |=> div_busy)
    else $error("divider did not start at window end");

endmodule

// ===== sv/spq_accum.sv =====
// ----------------------------------------------------------------------------
// spq_accum
// Qualifies each sample against the valid band and keeps the window sum,
// valid count and window position.
// ----------------------------------------------------------------------------
module spq_accum (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      smp_en_i,
  input  logic [spq_pkg::SMP_W-1:0] sample_i,
  input  logic [spq_pkg::SMP_W-1:0] valid_min_i,
  input  logic [spq_pkg::SMP_W-1:0] valid_max_i,
  input  logic                      clr_i,
  output spq_pkg::acc_t             acc_o
);

  logic [spq_pkg::SUM_W-1:0] sum_q, sum_d;
  logic [spq_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [spq_pkg::CNT_W-1:0] win_q, win_d;
  logic                      in_band;
  logic                      wrap;

  assign in_band = (sample_i >= valid_min_i) && (sample_i <= valid_max_i);
  assign wrap    = (win_q == spq_pkg::CNT_W'(spq_pkg::WINDOW - 1));

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    win_d = win_q;
    if (clr_i) begin
      sum_d = '0;
      cnt_d = '0;
    end else if (smp_en_i) begin
      if (in_band) begin
        sum_d = sum_q + spq_pkg::SUM_W'(sample_i);
        cnt_d = cnt_q + 1'b1;
      end
      win_d = wrap ? '0 : win_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
      win_q <= '0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
      win_q <= win_d;
    end
  end

  assign acc_o = '{sum: sum_q, count: cnt_q, wrap: wrap};

endmodule

// ===== sv/spq_div.sv =====
// ----------------------------------------------------------------------------
// spq_div
// Bit-serial restoring divider: one quotient bit per cycle, the dividend
// register shifting out its top bit as each quotient bit shifts in.
// ----------------------------------------------------------------------------
module spq_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [spq_pkg::SUM_W-1:0] dividend_i,
  input  logic [spq_pkg::CNT_W-1:0] divisor_i,
  output logic                      busy_o,
  output logic [spq_pkg::SMP_W-1:0] quot_o
);

  logic [spq_pkg::SUM_W-1:0]  dvd_q, dvd_d;
  logic [spq_pkg::CNT_W-1:0]  rem_q, rem_d;
  logic [spq_pkg::CNT_W-1:0]  dsr_q, dsr_d;
  logic [spq_pkg::STEP_W-1:0] step_q, step_d;
  logic                       busy_q, busy_d;
  logic [spq_pkg::CNT_W:0]    rem_sh;
  logic [spq_pkg::CNT_W:0]    rem_sub;
  logic                       fits;

  assign rem_sh  = {rem_q, dvd_q[spq_pkg::SUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, dsr_q};
  assign fits    = (rem_sh >= {1'b0, dsr_q});

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    step_d = step_q;
    busy_d = busy_q;
    if (start_i) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      step_d = spq_pkg::STEP_W'(spq_pkg::SUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d  = {dvd_q[spq_pkg::SUM_W-2:0], fits};
      rem_d  = fits ? rem_sub[spq_pkg::CNT_W-1:0] : rem_sh[spq_pkg::CNT_W-1:0];
      step_d = step_q - 1'b1;
      busy_d = (step_q != spq_pkg::STEP_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign busy_o = busy_q;
  assign quot_o = dvd_q[spq_pkg::SMP_W-1:0];

endmodule
